>>> design/tqps_pkg.sv
package tqps_pkg;

   // Field widths of the item channels and the limit register.
   localparam int ACTION_BITS = 2;
   localparam int ID_BITS     = 16;
   localparam int NOW_BITS    = 16;
   localparam int LIMIT_BITS  = 5;
   localparam int COUNT_BITS  = 32;

   // Defaults for the top-level parameters.
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TIME_BITS_DEF   = 16;

   // Value of the queue limit after reset.
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   // Request codes carried by an input item.
   typedef enum logic [ACTION_BITS-1:0] {
      ACTION_HIGH_REQ = 2'd0,
      ACTION_LOW_REQ  = 2'd1,
      ACTION_SERVE    = 2'd2
   } action_type;

   // What a result item reports.
   typedef enum logic [1:0] {
      ACTV_IDLE        = 2'd0,
      ACTV_SERVED_HIGH = 2'd1,
      ACTV_SERVED_LOW  = 2'd2,
      ACTV_REQUEST     = 2'd3
   } activity_type;

endpackage

>>> design/tqps_req_if.sv
interface tqps_req_if;
   import tqps_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ACTION_BITS-1:0] action;
   logic [ID_BITS-1:0]     item_id;
   logic [NOW_BITS-1:0]    now;

   modport source (output valid, output action, output item_id, output now, input ready);
   modport sink   (input valid, input action, input item_id, input now, output ready);

endinterface

>>> design/tqps_rsp_if.sv
interface tqps_rsp_if;
   import tqps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  accepted;
   logic [1:0]            activity;
   logic [ID_BITS-1:0]    served_id;
   logic [NOW_BITS-1:0]   served_arrival;
   logic [NOW_BITS-1:0]   served_wait;
   logic [COUNT_BITS-1:0] high_served_count;
   logic [COUNT_BITS-1:0] low_served_count;
   logic [COUNT_BITS-1:0] high_wait_sum;
   logic [COUNT_BITS-1:0] low_wait_sum;
   logic [COUNT_BITS-1:0] idle_count;
   logic [COUNT_BITS-1:0] high_refused_count;
   logic [COUNT_BITS-1:0] low_refused_count;

   modport source (
      output valid, output accepted, output activity, output served_id,
      output served_arrival, output served_wait, output high_served_count,
      output low_served_count, output high_wait_sum, output low_wait_sum,
      output idle_count, output high_refused_count, output low_refused_count,
      input ready
   );
   modport sink (
      input valid, input accepted, input activity, input served_id,
      input served_arrival, input served_wait, input high_served_count,
      input low_served_count, input high_wait_sum, input low_wait_sum,
      input idle_count, input high_refused_count, input low_refused_count,
      output ready
   );

endinterface

>>> design/two_queue_priority_server_unit.sv
// Channel   Direction  Handshake      Contents
// req_ch    in         valid/ready    action, item_id, now
// rsp_ch    out        valid/ready    served item data and seven statistic counters
// csr_*     in         write enable   occupancy limit shared by both queues (no read-back)
//
// A new item is accepted every cycle unless a
// finished result is waiting and rsp_ch.ready is low.
// The queue head is prefetched into a register each cycle, so a pop reads no RAM
// combinationally; the sustained rate is one item per cycle while results are taken.
// Reset is synchronous and clears occupancies, heads, counters and the limit (16).
// An item with the unused action code is taken and produces no result.
module two_queue_priority_server_unit #(
   parameter int QUEUE_DEPTH = tqps_pkg::QUEUE_DEPTH_DEF,
   parameter int TIME_BITS   = tqps_pkg::TIME_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   tqps_req_if.sink                        req_ch,
   tqps_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [tqps_pkg::LIMIT_BITS-1:0] csr_wdata
);
   import tqps_pkg::*;

   localparam int OccBits   = $clog2(QUEUE_DEPTH + 1);
   localparam int PtrBits   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SumBits   = OccBits + 1;
   localparam int StoreBits = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;
   localparam int CmpBits   = (OccBits > LIMIT_BITS) ? OccBits : LIMIT_BITS;
   localparam int EntryBits = ID_BITS + StoreBits;
   localparam int NumQueues = 2;
   localparam int QHigh     = 0;
   localparam int QLow      = 1;

   function automatic logic [COUNT_BITS-1:0] sat_add(
      input logic [COUNT_BITS-1:0] base,
      input logic [COUNT_BITS-1:0] amount
   );
      logic [COUNT_BITS:0] total;
      total = {1'b0, base} + {1'b0, amount};
      return total[COUNT_BITS] ? '1 : total[COUNT_BITS-1:0];
   endfunction

   // Configuration and queue control state.
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [OccBits-1:0]    occ_ff  [NumQueues];
   logic [OccBits-1:0]    occ_in  [NumQueues];
   logic [PtrBits-1:0]    head_ff [NumQueues];
   logic [PtrBits-1:0]    head_in [NumQueues];
   logic [EntryBits-1:0]  hd_ff   [NumQueues];
   logic                  push_ok [NumQueues];
   logic                  pop     [NumQueues];
   logic                  is_push [NumQueues];

   // Statistic counters.
   logic [COUNT_BITS-1:0] hi_served_ff, lo_served_ff, hi_wait_ff, lo_wait_ff;
   logic [COUNT_BITS-1:0] idle_ff, hi_refused_ff, lo_refused_ff;
   logic [COUNT_BITS-1:0] hi_served_in, lo_served_in, hi_wait_in, lo_wait_in;
   logic [COUNT_BITS-1:0] idle_in, hi_refused_in, lo_refused_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  accepted_ff, accepted_in;
   activity_type          activity_ff, activity_in;
   logic [ID_BITS-1:0]    sid_ff, sid_in;
   logic [NOW_BITS-1:0]   sarr_ff, sarr_in;
   logic [NOW_BITS-1:0]   swait_ff, swait_in;

   logic                  accept;
   logic                  tick;
   logic                  load_rsp;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  arr_t;
   logic [TIME_BITS-1:0]  wait_t;
   logic [EntryBits-1:0]  sel_entry;
   logic [EntryBits-1:0]  new_entry;

   // Input side handshake: the result register frees up when it is taken.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign now_t        = TIME_BITS'(req_ch.now[StoreBits-1:0]);
   assign new_entry    = {req_ch.item_id, req_ch.now[StoreBits-1:0]};

   // Decode the action of an accepted item.
   always_comb begin
      is_push[QHigh] = 1'b0;
      is_push[QLow]  = 1'b0;
      tick           = 1'b0;
      load_rsp       = 1'b0;
      if (accept) begin
         unique case (req_ch.action)
            ACTION_HIGH_REQ: begin
               is_push[QHigh] = 1'b1;
               load_rsp       = 1'b1;
            end
            ACTION_LOW_REQ: begin
               is_push[QLow] = 1'b1;
               load_rsp      = 1'b1;
            end
            ACTION_SERVE: begin
               tick     = 1'b1;
               load_rsp = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Strict priority: the high queue wins whenever it holds an item.
   assign pop[QHigh] = tick && (occ_ff[QHigh] != '0);
   assign pop[QLow]  = tick && (occ_ff[QHigh] == '0) && (occ_ff[QLow] != '0);

   // One FIFO per priority: a memory plus a prefetched head entry.
   for (genvar q = 0; q < NumQueues; q++) begin : g_queue
      logic [EntryBits-1:0] mem [QUEUE_DEPTH];
      logic [SumBits-1:0]   tail_sum;
      logic [PtrBits-1:0]   tail_slot;
      logic                 full;

      assign full = (CmpBits'(occ_ff[q]) >= CmpBits'(limit_ff)) ||
                    (occ_ff[q] >= OccBits'(QUEUE_DEPTH));
      assign push_ok[q] = is_push[q] && !full;

      // Tail slot is head plus occupancy, wrapped once.
      always_comb begin
         tail_sum = SumBits'(head_ff[q]) + SumBits'(occ_ff[q]);
         if (tail_sum >= SumBits'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SumBits'(QUEUE_DEPTH);
         end
         tail_slot = tail_sum[PtrBits-1:0];
      end

      // Next head and occupancy.
      always_comb begin
         head_in[q] = head_ff[q];
         if (pop[q]) begin
            head_in[q] = (head_ff[q] == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : head_ff[q] + 1'b1;
         end
         occ_in[q] = occ_ff[q];
         if (push_ok[q]) begin
            occ_in[q] = occ_ff[q] + 1'b1;
         end else if (pop[q]) begin
            occ_in[q] = occ_ff[q] - 1'b1;
         end
      end

      // Entry store; a push into an empty queue lands on the head directly.
      always_ff @(posedge clock) begin
         if (push_ok[q]) begin
            mem[tail_slot] <= new_entry;
         end
         if (push_ok[q] && occ_ff[q] == '0) begin
            hd_ff[q] <= new_entry;
         end else begin
            hd_ff[q] <= mem[head_in[q]];
         end
      end
   end

   // Served entry, wait and result fields.
   always_comb begin
      sel_entry   = pop[QHigh] ? hd_ff[QHigh] : hd_ff[QLow];
      arr_t       = TIME_BITS'(sel_entry[StoreBits-1:0]);
      wait_t      = now_t - arr_t;
      accepted_in = push_ok[QHigh] || push_ok[QLow];
      sid_in      = '0;
      sarr_in     = '0;
      swait_in    = '0;
      activity_in = ACTV_IDLE;
      if (is_push[QHigh] || is_push[QLow]) begin
         activity_in = ACTV_REQUEST;
      end else if (pop[QHigh] || pop[QLow]) begin
         activity_in = pop[QHigh] ? ACTV_SERVED_HIGH : ACTV_SERVED_LOW;
         sid_in      = sel_entry[EntryBits-1:StoreBits];
         sarr_in     = NOW_BITS'(arr_t);
         swait_in    = NOW_BITS'(wait_t);
      end
   end

   // Saturating statistic updates.
   always_comb begin
      hi_served_in  = pop[QHigh] ? sat_add(hi_served_ff, COUNT_BITS'(1)) : hi_served_ff;
      hi_wait_in    = pop[QHigh] ? sat_add(hi_wait_ff, COUNT_BITS'(wait_t)) : hi_wait_ff;
      lo_served_in  = pop[QLow] ? sat_add(lo_served_ff, COUNT_BITS'(1)) : lo_served_ff;
      lo_wait_in    = pop[QLow] ? sat_add(lo_wait_ff, COUNT_BITS'(wait_t)) : lo_wait_ff;
      idle_in       = (tick && !pop[QHigh] && !pop[QLow]) ?
                      sat_add(idle_ff, COUNT_BITS'(1)) : idle_ff;
      hi_refused_in = (is_push[QHigh] && !push_ok[QHigh]) ?
                      sat_add(hi_refused_ff, COUNT_BITS'(1)) : hi_refused_ff;
      lo_refused_in = (is_push[QLow] && !push_ok[QLow]) ?
                      sat_add(lo_refused_ff, COUNT_BITS'(1)) : lo_refused_ff;
   end

   // Control state, counters and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         occ_ff[QHigh] <= '0;
         occ_ff[QLow]  <= '0;
         head_ff[QHigh] <= '0;
         head_ff[QLow]  <= '0;
         hi_served_ff  <= '0;
         lo_served_ff  <= '0;
         hi_wait_ff    <= '0;
         lo_wait_ff    <= '0;
         idle_ff       <= '0;
         hi_refused_ff <= '0;
         lo_refused_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
         occ_ff[QHigh]  <= occ_in[QHigh];
         occ_ff[QLow]   <= occ_in[QLow];
         head_ff[QHigh] <= head_in[QHigh];
         head_ff[QLow]  <= head_in[QLow];
         hi_served_ff   <= hi_served_in;
         lo_served_ff   <= lo_served_in;
         hi_wait_ff     <= hi_wait_in;
         lo_wait_ff     <= lo_wait_in;
         idle_ff        <= idle_in;
         hi_refused_ff  <= hi_refused_in;
         lo_refused_ff  <= lo_refused_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         accepted_ff <= accepted_in;
         activity_ff <= activity_in;
         sid_ff      <= sid_in;
         sarr_ff     <= sarr_in;
         swait_ff    <= swait_in;
      end
   end

   // Counters only move when an item is accepted, so while a result waits
   // they still hold the values after that item.
   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.accepted           = accepted_ff;
   assign rsp_ch.activity           = activity_ff;
   assign rsp_ch.served_id          = sid_ff;
   assign rsp_ch.served_arrival     = sarr_ff;
   assign rsp_ch.served_wait        = swait_ff;
   assign rsp_ch.high_served_count  = hi_served_ff;
   assign rsp_ch.low_served_count   = lo_served_ff;
   assign rsp_ch.high_wait_sum      = hi_wait_ff;
   assign rsp_ch.low_wait_sum       = lo_wait_ff;
   assign rsp_ch.idle_count         = idle_ff;
   assign rsp_ch.high_refused_count = hi_refused_ff;
   assign rsp_ch.low_refused_count  = lo_refused_ff;

   // A queue never holds more than its depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff[QHigh] <= OccBits'(QUEUE_DEPTH) && occ_ff[QLow] <= OccBits'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   // Only a request result can report an accepted item.
   a_accept_is_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && accepted_ff |-> activity_ff == ACTV_REQUEST)
      else $error("accepted flag on a serve result");

   // A high pop takes exactly one item off the high queue.
   a_high_pop: assert property (@(posedge clock) disable iff (reset)
      pop[QHigh] |=> occ_ff[QHigh] == $past(occ_ff[QHigh]) - 1'b1)
      else $error("high queue occupancy not decremented on pop");

   // The idle counter moves only when both queues were empty.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && idle_ff != $past(idle_ff) |->
         $past(occ_ff[QHigh]) == '0 && $past(occ_ff[QLow]) == '0)
      else $error("idle slot counted with a queue non-empty");

   // A low pop never happens while the high queue holds items.
   a_priority: assert property (@(posedge clock) disable iff (reset)
      pop[QLow] |-> occ_ff[QHigh] == '0)
      else $error("low queue served ahead of high queue");

endmodule

>>> sim/two_queue_priority_server_unit_test.sv
module two_queue_priority_server_unit_test;
   import tqps_pkg::*;

   // Code with no meaning to the block: taken from the channel, no result.
   localparam logic [ACTION_BITS-1:0] ACTION_UNUSED = 2'd3;

   // Statistic counter slots, in the order they appear on the result channel.
   localparam int CNT_HIGH_SERVED  = 0;
   localparam int CNT_LOW_SERVED   = 1;
   localparam int CNT_HIGH_WAIT    = 2;
   localparam int CNT_LOW_WAIT     = 3;
   localparam int CNT_IDLE         = 4;
   localparam int CNT_HIGH_REFUSED = 5;
   localparam int CNT_LOW_REFUSED  = 6;
   localparam int NUM_COUNTERS     = 7;

   localparam int DEPTH           = QUEUE_DEPTH_DEF;
   localparam int IDLE_PCT        = 24;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_CYCLES     = 300;
   localparam int STUCK_LIMIT     = 2000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct packed {
      logic                                    accepted;
      activity_type                            activity;
      logic [ID_BITS-1:0]                      served_id;
      logic [NOW_BITS-1:0]                     served_arrival;
      logic [NOW_BITS-1:0]                     served_wait;
      logic [NUM_COUNTERS-1:0][COUNT_BITS-1:0] counters;
   } server_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [LIMIT_BITS-1:0] csr_wdata;

   tqps_req_if req_ch();
   tqps_rsp_if rsp_ch();

   two_queue_priority_server_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the server state.
   logic [ID_BITS-1:0]              high_ids   [DEPTH];
   logic [NOW_BITS-1:0]             high_times [DEPTH];
   logic [ID_BITS-1:0]              low_ids    [DEPTH];
   logic [NOW_BITS-1:0]             low_times  [DEPTH];
   logic [3:0]                      high_head = '0;
   logic [3:0]                      low_head  = '0;
   logic [4:0]                      high_fill = '0;
   logic [4:0]                      low_fill  = '0;
   logic [COUNT_BITS-1:0]           stats [NUM_COUNTERS] = '{default: '0};
   logic [LIMIT_BITS-1:0]           limit_shadow = LIMIT_RESET;

   server_result_type awaited_results[$];
   int             mismatch_count = 0;
   int             stuck_cycles = 0;
   bit             quiet = 1'b0;
   int             hold_requests = 0;
   int             holds_started = 0;
   int             hold_left = 0;
   logic [NOW_BITS-1:0] stamp = '0;

   // Clock generation.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] value,
                                                     logic [COUNT_BITS-1:0] amount);
      logic [COUNT_BITS:0] sum;
      sum = {1'b0, value} + {1'b0, amount};
      return sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
   endfunction

   // Advance the shadow state by one item and return the result it produces.
   function automatic server_result_type predict_server_step(
      logic [ACTION_BITS-1:0] action,
      logic [ID_BITS-1:0] id,
      logic [NOW_BITS-1:0] now);
      server_result_type res;
      logic [3:0]     slot;
      res = '0;
      if (action == ACTION_HIGH_REQ) begin
         res.activity = ACTV_REQUEST;
         if (high_fill < limit_shadow && high_fill < DEPTH) begin
            slot = high_head + high_fill[3:0];
            high_ids[slot] = id;
            high_times[slot] = now;
            high_fill++;
            res.accepted = 1'b1;
         end else begin
            stats[CNT_HIGH_REFUSED] = sat_add(stats[CNT_HIGH_REFUSED], 1);
         end
      end else if (action == ACTION_LOW_REQ) begin
         res.activity = ACTV_REQUEST;
         if (low_fill < limit_shadow && low_fill < DEPTH) begin
            slot = low_head + low_fill[3:0];
            low_ids[slot] = id;
            low_times[slot] = now;
            low_fill++;
            res.accepted = 1'b1;
         end else begin
            stats[CNT_LOW_REFUSED] = sat_add(stats[CNT_LOW_REFUSED], 1);
         end
      end else if (high_fill != 0) begin
         res.activity = ACTV_SERVED_HIGH;
         res.served_id = high_ids[high_head];
         res.served_arrival = high_times[high_head];
         res.served_wait = now - high_times[high_head];
         high_head++;
         high_fill--;
         stats[CNT_HIGH_SERVED] = sat_add(stats[CNT_HIGH_SERVED], 1);
         stats[CNT_HIGH_WAIT] = sat_add(stats[CNT_HIGH_WAIT],
                                        COUNT_BITS'(res.served_wait));
      end else if (low_fill != 0) begin
         res.activity = ACTV_SERVED_LOW;
         res.served_id = low_ids[low_head];
         res.served_arrival = low_times[low_head];
         res.served_wait = now - low_times[low_head];
         low_head++;
         low_fill--;
         stats[CNT_LOW_SERVED] = sat_add(stats[CNT_LOW_SERVED], 1);
         stats[CNT_LOW_WAIT] = sat_add(stats[CNT_LOW_WAIT],
                                       COUNT_BITS'(res.served_wait));
      end else begin
         res.activity = ACTV_IDLE;
         stats[CNT_IDLE] = sat_add(stats[CNT_IDLE], 1);
      end
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         res.counters[k] = stats[k];
      end
      return res;
   endfunction

   function automatic void check_field(string name, logic [COUNT_BITS-1:0] want,
                                       logic [COUNT_BITS-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
         end
      end
   endfunction

   // Predict on every accepted item with a used action code, then compare every accepted result.
   always @(posedge clock) begin
      server_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready && req_ch.action != ACTION_UNUSED) begin
            awaited_results.push_back(predict_server_step(req_ch.action, req_ch.item_id,
                                                          req_ch.now));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: result with none expected, activity %0d id 0x%0h",
                           $realtime, rsp_ch.activity, rsp_ch.served_id);
               end
            end else begin
               want = awaited_results.pop_front();
               check_field("accepted", COUNT_BITS'(want.accepted),
                           COUNT_BITS'(rsp_ch.accepted));
               check_field("activity", COUNT_BITS'(want.activity),
                           COUNT_BITS'(rsp_ch.activity));
               check_field("served_id", COUNT_BITS'(want.served_id),
                           COUNT_BITS'(rsp_ch.served_id));
               check_field("served_arrival", COUNT_BITS'(want.served_arrival),
                           COUNT_BITS'(rsp_ch.served_arrival));
               check_field("served_wait", COUNT_BITS'(want.served_wait),
                           COUNT_BITS'(rsp_ch.served_wait));
               check_field("high_served_count", want.counters[CNT_HIGH_SERVED],
                           rsp_ch.high_served_count);
               check_field("low_served_count", want.counters[CNT_LOW_SERVED],
                           rsp_ch.low_served_count);
               check_field("high_wait_sum", want.counters[CNT_HIGH_WAIT],
                           rsp_ch.high_wait_sum);
               check_field("low_wait_sum", want.counters[CNT_LOW_WAIT],
                           rsp_ch.low_wait_sum);
               check_field("idle_count", want.counters[CNT_IDLE], rsp_ch.idle_count);
               check_field("high_refused_count", want.counters[CNT_HIGH_REFUSED],
                           rsp_ch.high_refused_count);
               check_field("low_refused_count", want.counters[CNT_LOW_REFUSED],
                           rsp_ch.low_refused_count);
            end
         end
      end
   end

   // Result receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (holds_started != hold_requests) begin
         holds_started++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("two_queue_priority_server_unit: mismatch");
         $finish;
      end
   end

   // Offer one item, with random idle cycles ahead of it, and wait for acceptance.
   task automatic send_item(logic [ACTION_BITS-1:0] action, logic [ID_BITS-1:0] id,
                            logic [NOW_BITS-1:0] now);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= action;
      req_ch.item_id <= id;
      req_ch.now <= now;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stop offering and wait until every expected result has come back.
   // The first edge lets the last accepted item reach the expected queue.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_fill_limit(logic [LIMIT_BITS-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_shadow = value;
   endtask

   // Mostly a slowly advancing clock, sometimes an arbitrary time value.
   function automatic logic [NOW_BITS-1:0] next_stamp();
      if ($urandom_range(4) == 0) begin
         return NOW_BITS'($urandom);
      end
      stamp = stamp + NOW_BITS'($urandom_range(40));
      return stamp;
   endfunction

   // Random mix of requests to both queues, serve ticks and unused codes.
   task automatic run_traffic(int count, int req_pct);
      int                     pick;
      logic [ACTION_BITS-1:0] action;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            action = ACTION_UNUSED;
         end else if (pick < 3 + req_pct) begin
            action = $urandom_range(1) ? ACTION_LOW_REQ : ACTION_HIGH_REQ;
         end else begin
            action = ACTION_SERVE;
         end
         send_item(action, ID_BITS'($urandom), next_stamp());
      end
   endtask

   // Empty ticks, extreme fields, priority order and a wait that wraps around.
   task automatic test_basic_service();
      send_item(ACTION_SERVE, 16'h0000, 16'h0000);
      send_item(ACTION_HIGH_REQ, 16'hFFFF, 16'hFFFF);
      send_item(ACTION_LOW_REQ, 16'h0000, 16'h0000);
      send_item(ACTION_LOW_REQ, 16'h1234, 16'h8000);
      send_item(ACTION_HIGH_REQ, 16'h0000, 16'h0000);
      send_item(ACTION_SERVE, 16'hFFFF, 16'h0000);
      send_item(ACTION_SERVE, 16'h0000, 16'hFFFF);
      send_item(ACTION_SERVE, 16'h0000, 16'h0100);
      send_item(ACTION_UNUSED, 16'hFFFF, 16'hFFFF);
      send_item(ACTION_SERVE, 16'h0000, 16'h7FFF);
      send_item(ACTION_SERVE, 16'h5555, 16'hFFFF);
   endtask

   // A zero limit refuses every request on both queues.
   task automatic test_limit_zero();
      write_fill_limit(5'd0);
      send_item(ACTION_HIGH_REQ, 16'hAAAA, 16'h0001);
      send_item(ACTION_LOW_REQ, 16'h5555, 16'h0002);
      send_item(ACTION_SERVE, 16'h0000, 16'h0003);
      run_traffic(90, 60);
   endtask

   // Limits above the depth: the queues still stop at sixteen entries.
   task automatic test_queue_overflow();
      write_fill_limit(5'd31);
      run_traffic(200, 75);
      write_fill_limit(LIMIT_RESET);
      run_traffic(150, 70);
   endtask

   task automatic test_single_slot();
      write_fill_limit(5'd1);
      run_traffic(150, 50);
   endtask

   task automatic test_balanced_traffic();
      write_fill_limit(LIMIT_RESET);
      run_traffic(300, 50);
   endtask

   task automatic test_back_to_back();
      write_fill_limit(5'd8);
      quiet = 1'b1;
      run_traffic(250, 50);
      quiet = 1'b0;
   endtask

   // Receiver holds off while items keep coming, so the input must stall.
   task automatic test_output_backpressure();
      write_fill_limit(5'd12);
      hold_requests++;
      run_traffic(100, 50);
      wait_drained();
   endtask

   task automatic test_random_limits();
      repeat (4) begin
         write_fill_limit(LIMIT_BITS'($urandom_range(31)));
         run_traffic(130, $urandom_range(30, 70));
      end
   endtask

   // Mostly ticks, so the queues run dry and idle slots are counted.
   task automatic test_drain_to_idle();
      write_fill_limit(5'd3);
      run_traffic(100, 15);
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.action = ACTION_HIGH_REQ;
      req_ch.item_id = '0;
      req_ch.now = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_service();
      test_limit_zero();
      test_queue_overflow();
      test_single_slot();
      test_balanced_traffic();
      test_back_to_back();
      test_output_backpressure();
      test_random_limits();
      test_drain_to_idle();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0) begin
         $display("two_queue_priority_server_unit: match");
      end else begin
         $display("two_queue_priority_server_unit: mismatch");
      end
      $finish;
   end

endmodule
